### hdl/cef_pkg.sv
`default_nettype none

package cef_pkg;

	// Field widths of one entry
	localparam int unsigned KEY_W   = 64;
	localparam int unsigned SEQ_W   = 56;
	localparam int unsigned TYPE_W  = 8;
	localparam int unsigned VALUE_W = 64;

	// Packed stream word: key, sequence, type, value from the lowest bit up
	localparam int unsigned DATA_W  = KEY_W + SEQ_W + TYPE_W + VALUE_W;
	localparam int unsigned SEQ_LSB   = KEY_W;
	localparam int unsigned TYPE_LSB  = SEQ_LSB + SEQ_W;
	localparam int unsigned VALUE_LSB = TYPE_LSB + TYPE_W;

	// Configuration port
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned PLEN_W     = 4;

	localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PREFIX_VALUE   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PREFIX_LENGTH  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SEQUENCE_BOUND = 2'd3;

	localparam logic [MODE_W-1:0] MODE_REDUNDANT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PREFIX    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_VERSION   = 2'd2;

	localparam logic [TYPE_W-1:0] DELETION_TYPE = 8'd0;

	// Defaults for the top-level parameters
	localparam int unsigned USER_KEY_BYTES_DEF = 8;
	localparam int unsigned VALUE_BYTES_DEF    = 8;
	localparam int unsigned OUTQ_DEPTH         = 4;

	typedef struct packed {
		logic [VALUE_W-1:0] val;
		logic [TYPE_W-1:0]  typ;
		logic [SEQ_W-1:0]   seq;
		logic [KEY_W-1:0]   key;
		logic               rewritten;
		logic               last;
	} cef_result_t;

	// True when the leading plen bytes of a kb-byte key equal the
	// left-aligned prefix bytes. A prefix longer than the key never matches.
	function automatic logic prefix_hit(
		input logic [KEY_W-1:0]      key,
		input logic [PLEN_W-1:0]     plen,
		input logic [CFG_DATA_W-1:0] pval,
		input int unsigned           kb
	);
		logic             hit;
		logic [KEY_W-1:0] kshift;
		hit = (int'(plen) <= int'(kb));
		for (int i = 0; i < 8; i++) begin
			if ((i < int'(plen)) && (i < int'(kb))) begin
				kshift = key >> (8 * (int'(kb) - 1 - i));
				if (kshift[7:0] != pval[8*(7-i) +: 8])
					hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

### hdl/compaction_entry_filter_top.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata: entry_key, sequence_req, entry_type, value; tlast: end_of_stream
// m_axis   | out       | tdata: out_key, out_sequence, out_entry_type, out_value;
//          |           | tuser: was_rewritten; tlast: final_marker
// cfg      | in        | cfg_we, cfg_addr (register index), cfg_wdata
//
// One entry is taken per cycle. Its results are decided in the accepting cycle
// from the held entry and the new one and written into a four-slot output queue,
// from which they leave on m_axis in order. An end-of-stream entry gives up to two
// results, so the input stalls whenever fewer than two queue slots are free. Reset
// empties the holder and the queue and clears the registers.
`default_nettype none

module compaction_entry_filter_top #(
	parameter int unsigned USER_KEY_BYTES = cef_pkg::USER_KEY_BYTES_DEF,
	parameter int unsigned VALUE_BYTES    = cef_pkg::VALUE_BYTES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// entry_key[63:0], sequence_req[119:64], entry_type[127:120], value[191:128]
	input  wire  [cef_pkg::DATA_W-1:0]       s_axis_tdata,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire                              s_axis_tlast,
	// out_key[63:0], out_sequence[119:64], out_entry_type[127:120],
	// out_value[191:128]
	output logic [cef_pkg::DATA_W-1:0]       m_axis_tdata,
	// was_rewritten[0]
	output logic [0:0]                       m_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic                             m_axis_tlast,
	input  wire                              cfg_we,
	input  wire  [cef_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire  [cef_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import cef_pkg::*;

	localparam int unsigned HK_W = 8 * USER_KEY_BYTES;
	localparam int unsigned HV_W = 8 * VALUE_BYTES;

	logic [MODE_W-1:0]     filter_mode_q;
	logic [CFG_DATA_W-1:0] prefix_value_q;
	logic [PLEN_W-1:0]     prefix_length_q;
	logic [SEQ_W-1:0]      sequence_bound_q;

	logic                  held_valid_q;
	logic [HK_W-1:0]       held_key_q;
	logic [SEQ_W-1:0]      held_seq_q;
	logic [TYPE_W-1:0]     held_type_q;
	logic [HV_W-1:0]       held_val_q;

	logic [HK_W-1:0]       in_key;
	logic [SEQ_W-1:0]      in_seq;
	logic [TYPE_W-1:0]     in_type;
	logic [HV_W-1:0]       in_val;

	logic                  accept;
	logic                  room2;
	logic                  same_key;
	logic                  held_in_prefix;
	logic                  in_in_prefix;
	logic                  held_rewrite;
	logic                  flush_rewrite;
	logic                  push_a;
	logic                  push_b;
	cef_result_t           res_a;
	cef_result_t           res_b;
	cef_result_t           head;

	// Keep only the key and value bytes in use
	assign in_key  = s_axis_tdata[HK_W-1:0];
	assign in_seq  = s_axis_tdata[SEQ_LSB +: SEQ_W];
	assign in_type = s_axis_tdata[TYPE_LSB +: TYPE_W];
	assign in_val  = s_axis_tdata[VALUE_LSB +: HV_W];

	assign s_axis_tready = room2;
	assign accept        = s_axis_tvalid && room2;

	assign same_key       = (held_key_q == in_key);
	assign held_in_prefix = prefix_hit(KEY_W'(held_key_q), prefix_length_q, prefix_value_q,
		USER_KEY_BYTES);
	assign in_in_prefix   = prefix_hit(KEY_W'(in_key), prefix_length_q, prefix_value_q,
		USER_KEY_BYTES);

	always_comb begin
		case (filter_mode_q)
			MODE_REDUNDANT: held_rewrite = same_key;
			MODE_PREFIX:    held_rewrite = held_in_prefix;
			MODE_VERSION:   held_rewrite = held_in_prefix && same_key &&
				(held_seq_q < sequence_bound_q);
			default:        held_rewrite = 1'b0;
		endcase
	end

	// A flushed entry has no successor: only the prefix rule can rewrite it
	assign flush_rewrite = (filter_mode_q == MODE_PREFIX) && in_in_prefix;

	assign push_a = accept && held_valid_q;
	assign push_b = accept && s_axis_tlast;

	always_comb begin
		res_a.key       = KEY_W'(held_key_q);
		res_a.seq       = held_seq_q;
		res_a.typ       = held_rewrite ? DELETION_TYPE : held_type_q;
		res_a.val       = VALUE_W'(held_val_q);
		res_a.rewritten = held_rewrite;
		res_a.last      = 1'b0;

		res_b.key       = KEY_W'(in_key);
		res_b.seq       = in_seq;
		res_b.typ       = flush_rewrite ? DELETION_TYPE : in_type;
		res_b.val       = VALUE_W'(in_val);
		res_b.rewritten = flush_rewrite;
		res_b.last      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q    <= '0;
			prefix_value_q   <= '0;
			prefix_length_q  <= '0;
			sequence_bound_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FILTER_MODE:    filter_mode_q    <= cfg_wdata[MODE_W-1:0];
				REG_PREFIX_VALUE:   prefix_value_q   <= cfg_wdata;
				REG_PREFIX_LENGTH:  prefix_length_q  <= cfg_wdata[PLEN_W-1:0];
				REG_SEQUENCE_BOUND: sequence_bound_q <= cfg_wdata[SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the newest entry; end of stream leaves the holder empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (accept) begin
			held_valid_q <= !s_axis_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_key_q  <= in_key;
			held_seq_q  <= in_seq;
			held_type_q <= in_type;
			held_val_q  <= in_val;
		end
	end

	cef_outq #(
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_a       (push_a),
		.data_a       (res_a),
		.push_b       (push_b),
		.data_b       (res_b),
		.room2        (room2),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.head         (head)
	);

	assign m_axis_tdata = {head.val, head.typ, head.seq, head.key};
	assign m_axis_tuser = head.rewritten;
	assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

### hdl/cef_outq.sv
`default_nettype none

module cef_outq #(
	parameter int unsigned DEPTH = cef_pkg::OUTQ_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push_a,
	input  cef_pkg::cef_result_t data_a,
	input  wire                 push_b,
	input  cef_pkg::cef_result_t data_b,
	output logic                room2,
	output logic                m_axis_tvalid,
	input  wire                 m_axis_tready,
	output cef_pkg::cef_result_t head
);
	import cef_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cef_result_t     entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   wr_b;
	logic            pop;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (count_q != '0);
	assign room2         = (count_q <= CW'(DEPTH - 2));
	assign head          = entry_q[rd_ptr_q];
	assign wr_b          = push_a ? bump(wr_ptr_q) : wr_ptr_q;

	always_ff @(posedge clk) begin
		if (push_a)
			entry_q[wr_ptr_q] <= data_a;
		if (push_b)
			entry_q[wr_b] <= data_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_b)
				wr_ptr_q <= bump(wr_b);
			else if (push_a)
				wr_ptr_q <= wr_b;
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			count_q <= count_q + CW'(push_a) + CW'(push_b) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

### tb/compaction_entry_filter_top_tb.sv
`timescale 1ns / 1ps

module compaction_entry_filter_top_tb;
	import cef_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [SEQ_W-1:0]  SEQ_MAX     = {SEQ_W{1'b1}};
	localparam logic [KEY_W-1:0]  KEY_MAX     = {KEY_W{1'b1}};
	localparam int unsigned       CYCLE_LIMIT = 200000;
	localparam int unsigned       IDLE_PCT    = 32;

	typedef struct packed {
		logic [VALUE_W-1:0] val;
		logic [TYPE_W-1:0]  typ;
		logic [SEQ_W-1:0]   seq;
		logic [KEY_W-1:0]   key;
		logic               eos;
	} entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic [DATA_W-1:0]     s_axis_tdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic                  s_axis_tlast = 1'b0;
	logic [DATA_W-1:0]     m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic                  m_axis_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	compaction_entry_filter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Filter settings as the block should hold them
	logic [MODE_W-1:0]     cur_mode = MODE_REDUNDANT;
	logic [CFG_DATA_W-1:0] cur_prefix = '0;
	logic [PLEN_W-1:0]     cur_plen = '0;
	logic [SEQ_W-1:0]      cur_bound = '0;

	// Entry held back by the filter
	entry_t held_entry;
	logic   held_ok = 1'b0;

	entry_t      entries_to_send[$];
	cef_result_t results_due[$];
	cef_result_t want;

	logic        quiet = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic key_has_prefix(logic [KEY_W-1:0] k);
		if (cur_plen > 4'd8)
			return 1'b0;
		for (int b = 0; b < 8; b++)
			if (b < cur_plen && k[63-8*b -: 8] != cur_prefix[63-8*b -: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic cef_result_t emitted(entry_t e, logic tomb, logic last);
		cef_result_t r;
		r.key = e.key;
		r.seq = e.seq;
		r.typ = tomb ? DELETION_TYPE : e.typ;
		r.val = e.val;
		r.rewritten = tomb;
		r.last = last;
		return r;
	endfunction

	// Emit the held entry against e; hold e, or emit e too at end of stream
	task automatic apply_filter(entry_t e);
		logic tomb;
		if (held_ok) begin
			case (cur_mode)
				MODE_REDUNDANT: tomb = (held_entry.key == e.key);
				MODE_PREFIX: tomb = key_has_prefix(held_entry.key);
				MODE_VERSION: tomb = key_has_prefix(held_entry.key) &&
					(held_entry.key == e.key) && (held_entry.seq < cur_bound);
				default: tomb = 1'b0;
			endcase
			results_due.insert(results_due.size(), emitted(held_entry, tomb, 1'b0));
		end
		held_entry = e;
		held_ok = 1'b1;
		if (e.eos) begin
			results_due.insert(results_due.size(),
				emitted(e, (cur_mode == MODE_PREFIX) && key_has_prefix(e.key), 1'b1));
			held_ok = 1'b0;
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp_val);
		mismatches++;
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				apply_filter({s_axis_tdata[VALUE_LSB +: VALUE_W], s_axis_tdata[TYPE_LSB +: TYPE_W],
					s_axis_tdata[SEQ_LSB +: SEQ_W], s_axis_tdata[KEY_W-1:0], s_axis_tlast});
			if (!s_axis_tvalid || s_axis_tready) begin
				if (entries_to_send.size() != 0 &&
					(quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
					s_axis_tdata <= {entries_to_send[0].val, entries_to_send[0].typ,
						entries_to_send[0].seq, entries_to_send[0].key};
					s_axis_tlast <= entries_to_send[0].eos;
					s_axis_tvalid <= 1'b1;
					void'(entries_to_send.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					report_mismatch("unexpected result key", m_axis_tdata[KEY_W-1:0], '0);
				end else begin
					want = results_due.pop_front();
					if (m_axis_tdata[KEY_W-1:0] !== want.key)
						report_mismatch("user key", m_axis_tdata[KEY_W-1:0], want.key);
					if (m_axis_tdata[SEQ_LSB +: SEQ_W] !== want.seq)
						report_mismatch("sequence", 64'(m_axis_tdata[SEQ_LSB +: SEQ_W]),
							64'(want.seq));
					if (m_axis_tdata[TYPE_LSB +: TYPE_W] !== want.typ)
						report_mismatch("entry type", 64'(m_axis_tdata[TYPE_LSB +: TYPE_W]),
							64'(want.typ));
					if (m_axis_tdata[VALUE_LSB +: VALUE_W] !== want.val)
						report_mismatch("value", m_axis_tdata[VALUE_LSB +: VALUE_W], want.val);
					if (m_axis_tuser[0] !== want.rewritten)
						report_mismatch("rewritten flag", 64'(m_axis_tuser[0]),
							64'(want.rewritten));
					if (m_axis_tlast !== want.last)
						report_mismatch("final marker", 64'(m_axis_tlast), 64'(want.last));
				end
			end
			m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("compaction_entry_filter_top_tb: errors");
			$finish;
		end
	end

	// Hold until every request is sent and every result is back, then let the block settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (entries_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_FILTER_MODE: cur_mode = data[MODE_W-1:0];
			REG_PREFIX_VALUE: cur_prefix = data;
			REG_PREFIX_LENGTH: cur_plen = data[PLEN_W-1:0];
			REG_SEQUENCE_BOUND: cur_bound = data[SEQ_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_filter(logic [MODE_W-1:0] mode, logic [63:0] prefix,
		logic [PLEN_W-1:0] plen, logic [SEQ_W-1:0] bound);
		wait_drained();
		write_reg(REG_FILTER_MODE, CFG_DATA_W'(mode));
		write_reg(REG_PREFIX_VALUE, prefix);
		write_reg(REG_PREFIX_LENGTH, CFG_DATA_W'(plen));
		write_reg(REG_SEQUENCE_BOUND, CFG_DATA_W'(bound));
		@(negedge clk);
	endtask

	task automatic push_entry(logic [63:0] key, logic [SEQ_W-1:0] seq, logic [7:0] typ,
		logic [63:0] val, logic eos);
		entry_t e;
		e.key = key;
		e.seq = seq;
		e.typ = typ;
		e.val = val;
		e.eos = eos;
		entries_to_send.insert(entries_to_send.size(), e);
	endtask

	// Key biased towards repeats and the configured prefix so that rewrites happen
	function automatic logic [63:0] pick_key(logic [63:0] prev);
		int unsigned r;
		logic [63:0] pm;
		r = $urandom_range(0, 99);
		pm = (cur_plen >= 4'd8) ? KEY_MAX : ~(KEY_MAX >> (8 * cur_plen));
		if (r < 35)
			return prev;
		else if (r < 65)
			return (cur_prefix & pm) | (rand64() & ~pm);
		else if (r < 75)
			return rand64();
		else if (r < 80)
			return $urandom_range(0, 1) ? KEY_MAX : '0;
		else
			return prev + $urandom_range(1, 300);
	endfunction

	function automatic logic [SEQ_W-1:0] pick_seq();
		if ($urandom_range(0, 2) == 0)
			return cur_bound + SEQ_W'($urandom_range(0, 2)) - 1'b1;
		return SEQ_W'(rand64());
	endfunction

	initial begin
		logic [63:0]      run_key;
		logic [63:0]      pv;
		logic [PLEN_W-1:0] pl;
		logic [SEQ_W-1:0] sb;
		int unsigned      run_len;
		int unsigned      sent;
		int unsigned      r;
		logic             paused;
		logic             eos;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Redundant-key mode straight after reset, field extremes
		push_entry('0, '0, 8'h00, '0, 1'b0);
		push_entry('0, SEQ_MAX, 8'h01, KEY_MAX, 1'b0);
		push_entry(KEY_MAX, SEQ_MAX, 8'hFF, KEY_MAX, 1'b0);
		push_entry(KEY_MAX, '0, 8'h80, '0, 1'b1);
		// Flush with an empty holder
		push_entry(64'h0123_4567_89AB_CDEF, 56'h12_3456, 8'h11, 64'h55AA_55AA_55AA_55AA, 1'b1);

		set_filter(MODE_PREFIX, 64'hA5C3_0000_0000_0000, 4'd2, SEQ_MAX);
		push_entry(64'hA5C3_1111_2222_3333, 56'd7, 8'h01, 64'd1, 1'b0);
		push_entry(64'hA5C2_FFFF_FFFF_FFFF, 56'd8, 8'h01, 64'd2, 1'b0);
		push_entry(64'hA5C3_0000_0000_0000, 56'd9, 8'h02, 64'd3, 1'b1);

		// Zero-length prefix matches every key
		set_filter(MODE_PREFIX, KEY_MAX, 4'd0, '0);
		push_entry(rand64(), SEQ_W'(rand64()), 8'h01, rand64(), 1'b0);
		push_entry(rand64(), SEQ_W'(rand64()), 8'h01, rand64(), 1'b1);

		set_filter(MODE_PREFIX, 64'h8000_0000_0000_0001, 4'd8, 56'd1);
		push_entry(64'h8000_0000_0000_0001, 56'd1, 8'h01, 64'd10, 1'b0);
		push_entry(64'h8000_0000_0000_0000, 56'd2, 8'h01, 64'd11, 1'b0);
		push_entry(64'h8000_0000_0000_0001, 56'd3, 8'h01, 64'd12, 1'b1);

		// Prefix longer than the key never matches
		set_filter(MODE_PREFIX, 64'h8000_0000_0000_0001, 4'd9, 56'd1);
		push_entry(64'h8000_0000_0000_0001, 56'd4, 8'h01, 64'd13, 1'b0);
		push_entry(64'h8000_0000_0000_0001, 56'd5, 8'h01, 64'd14, 1'b1);

		// Old versions: below, at the bound, key change, flush inside the prefix
		set_filter(MODE_VERSION, 64'h4200_0000_0000_0000, 4'd1, 56'd100);
		push_entry(64'h4200_0000_0000_0001, 56'd99, 8'h01, 64'd20, 1'b0);
		push_entry(64'h4200_0000_0000_0001, 56'd100, 8'h01, 64'd21, 1'b0);
		push_entry(64'h4200_0000_0000_0001, 56'd5, 8'h01, 64'd22, 1'b0);
		push_entry(64'h4200_0000_0000_0002, 56'd1, 8'h01, 64'd23, 1'b0);
		push_entry(64'h4200_0000_0000_0002, 56'd0, 8'h01, 64'd24, 1'b1);

		// Unused mode passes everything
		set_filter(MODE_UNUSED, '0, 4'd0, SEQ_MAX);
		push_entry(64'd5, 56'd2, 8'h01, 64'd30, 1'b0);
		push_entry(64'd5, 56'd1, 8'h01, 64'd31, 1'b1);

		for (int ph = 0; ph < 6; ph++) begin
			pv = (ph == 1) ? KEY_MAX : rand64();
			r = $urandom_range(0, 10);
			pl = (r == 10) ? 4'd15 : PLEN_W'(r);
			sb = (ph == 2) ? '0 : (ph == 3) ? SEQ_MAX : SEQ_W'(rand64());
			set_filter((ph < 4) ? MODE_W'(ph) : MODE_W'($urandom_range(0, 3)), pv, pl, sb);
			quiet = (ph == 1);
			sent = 0;
			paused = 1'b0;
			run_key = rand64();
			while (sent < 70) begin
				if (ph == 2 && sent >= 35 && !paused) begin
					wait_drained();
					paused = 1'b1;
				end
				run_len = $urandom_range(1, 10);
				for (int i = 0; i < run_len; i++) begin
					run_key = pick_key(run_key);
					if (i == run_len - 1)
						eos = ($urandom_range(0, 9) != 0);
					else
						eos = ($urandom_range(0, 19) == 0);
					push_entry(run_key, pick_seq(),
						$urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 1)) : 8'($urandom),
						rand64(), eos);
					sent++;
				end
			end
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("compaction_entry_filter_top_tb: clean");
		else
			$display("compaction_entry_filter_top_tb: errors");
		$finish;
	end

endmodule

### compaction_entry_filter_top.f
hdl/cef_pkg.sv
hdl/cef_outq.sv
hdl/compaction_entry_filter_top.sv
tb/compaction_entry_filter_top_tb.sv
